@@ hdl/vlp_pkg.sv @@
// ----------------------------------------------------------------------------
// vlp_pkg
// Shared types and constants for the volume local peak top list block.
// ----------------------------------------------------------------------------
`default_nettype none

package vlp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIZE_X     = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y     = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z     = 2'd2;
    localparam logic [1:0] CFG_PEAK_COUNT = 2'd3;

    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_NBR,
        S_DRAIN,
        S_INSERT,
        S_ADV,
        S_EMIT
    } t_state;

    // Control shared by every list cell.
    typedef struct packed {
        logic seed;
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hdl/vlp_in_if.sv @@
// ----------------------------------------------------------------------------
// vlp_in_if
// Sample channel: one voxel value per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlp_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ hdl/vlp_out_if.sv @@
// ----------------------------------------------------------------------------
// vlp_out_if
// Peak channel: one list entry per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlp_out_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  rank;
    logic signed [31:0] peak_value;
    logic        [5:0]  peak_x;
    logic        [5:0]  peak_y;
    logic        [5:0]  peak_z;
    logic               last_peak;

    modport source (output valid, output rank, output peak_value, output peak_x,
                    output peak_y, output peak_z, output last_peak, input ready);
    modport sink   (input valid, input rank, input peak_value, input peak_x,
                    input peak_y, input peak_z, input last_peak, output ready);
endinterface

`default_nettype wire

@@ hdl/vlp_ram.sv @@
// ----------------------------------------------------------------------------
// vlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12288
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

@@ hdl/vlp_cell.sv @@
// ----------------------------------------------------------------------------
// vlp_cell
// One entry of the descending peak list. Takes the candidate, shifts down
// from its upper neighbor on insert, and shifts up from its lower neighbor
// while the list is read out.
// ----------------------------------------------------------------------------
`default_nettype none

module vlp_cell #(
    parameter int VW = 32,
    parameter int CRW = 18
) (
    input  wire logic                 i_clk,
    input  wire vlp_pkg::t_cell_ctl   i_ctl,
    input  wire logic                 i_en,
    input  wire logic signed [VW-1:0] i_cand_val,
    input  wire logic [CRW-1:0]       i_cand_crd,
    input  wire logic                 i_prev_ge,
    input  wire logic signed [VW-1:0] i_prev_val,
    input  wire logic [CRW-1:0]       i_prev_crd,
    input  wire logic signed [VW-1:0] i_next_val,
    input  wire logic [CRW-1:0]       i_next_crd,
    output logic                      o_ge,
    output logic                      o_gt,
    output logic signed [VW-1:0]      o_val,
    output logic [CRW-1:0]            o_crd
);
    logic signed [VW-1:0] r_val;
    logic [CRW-1:0]       r_crd;

    assign o_ge  = i_cand_val >= r_val;
    assign o_gt  = i_cand_val > r_val;
    assign o_val = r_val;
    assign o_crd = r_crd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.seed) begin
            r_val <= i_cand_val;
            r_crd <= '0;
        end else if (i_ctl.ins && i_en) begin
            // An upper cell that also takes or shifts pushes its entry down.
            if (i_prev_ge) begin
                r_val <= i_prev_val;
                r_crd <= i_prev_crd;
            end else if (o_ge) begin
                r_val <= i_cand_val;
                r_crd <= i_cand_crd;
            end
        end else if (i_ctl.pop) begin
            r_val <= i_next_val;
            r_crd <= i_next_crd;
        end
    end
endmodule

`default_nettype wire

@@ hdl/volume_local_peak_top_list.sv @@
// ----------------------------------------------------------------------------
// volume_local_peak_top_list
// Streaming 3-D local peak finder that keeps the largest peaks in a sorted
// row of list cells and reads them out after the final voxel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                    Handshake
//  i_smp     in   sample                                     valid/ready
//  o_pk      out  rank, peak_value, peak_x/y/z, last_peak    valid/ready
//  i_cfg_*   in   index, data                                write enable
//
//  A voxel at an interior window position passes through the write, the
//  center read, the neighbor reads through the single read port of the
//  plane RAM, the drain, the insert and the advance state. Other voxels go
//  from the write straight to the advance state. Readout gives one entry
//  per cycle while o_pk.ready is high and stalls with it. Reset restores
//  the register defaults and an empty scan; the plane RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_local_peak_top_list #(
    parameter int MAX_SIZE_X   = 64,
    parameter int MAX_SIZE_Y   = 64,
    parameter int MAX_SIZE_Z   = 64,
    parameter int MAX_PEAKS    = 8,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    vlp_in_if.sink                                    i_smp,
    vlp_out_if.source                                 o_pk,
    input  wire logic                                 i_cfg_we,
    input  wire logic [vlp_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  wire logic [vlp_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);
    localparam int XW    = $clog2(MAX_SIZE_X);
    localparam int YW    = $clog2(MAX_SIZE_Y);
    localparam int ZW    = $clog2(MAX_SIZE_Z);
    localparam int CRW   = XW + YW + ZW;
    localparam int EW    = 11;
    localparam int KW    = $clog2(MAX_PEAKS + 1);
    localparam int PIW   = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int PLANE = MAX_SIZE_Y * MAX_SIZE_Z;
    localparam int DEPTH = 3 * PLANE;
    localparam int AW    = $clog2(DEPTH);

    vlp_pkg::t_state r_state, n_state;

    logic [6:0]    r_size_x, r_size_y, r_size_z;
    logic [3:0]    r_peak_count;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [ZW-1:0] r_z;
    logic [1:0]    r_plane;
    logic          r_first_seen;
    logic [1:0]    r_ax, r_ay, r_az;
    logic          r_rd_ctr, r_rd_nbr;
    logic          r_ok;
    logic signed [SAMPLE_WIDTH-1:0] r_cand;
    logic [KW-1:0] r_rank;

    logic [EW-1:0] w_nx, w_ny, w_nz;
    logic [6:0]    w_k7;
    logic [KW-1:0] w_k, w_km1;
    logic          w_accept, w_judge, w_end_z, w_end_y, w_end_x, w_nbr_last;
    logic          w_out_xfer, w_out_last, w_insert;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [SAMPLE_WIDTH-1:0] w_rdata;
    logic signed [SAMPLE_WIDTH-1:0] w_rd_s;
    vlp_pkg::t_cell_ctl w_ctl;

    logic signed [SAMPLE_WIDTH-1:0] w_val [MAX_PEAKS];
    logic [CRW-1:0] w_crd [MAX_PEAKS];
    logic [MAX_PEAKS-1:0] w_ge, w_gt;
    logic [CRW-1:0] w_cand_crd;

    function automatic logic [1:0] f_mod3(input logic [2:0] s);
        f_mod3 = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [1:0] p, input logic [YW-1:0] y,
                                             input logic [ZW-1:0] z);
        f_addr = AW'(p) * AW'(PLANE) + AW'(y) * AW'(MAX_SIZE_Z) + AW'(z);
    endfunction

    // Effective extents and list length after clamping.
    always_comb begin
        w_nx = (r_size_x == 7'd0) ? EW'(1) :
               ((EW'(r_size_x) > EW'(MAX_SIZE_X)) ? EW'(MAX_SIZE_X) : EW'(r_size_x));
        w_ny = (r_size_y == 7'd0) ? EW'(1) :
               ((EW'(r_size_y) > EW'(MAX_SIZE_Y)) ? EW'(MAX_SIZE_Y) : EW'(r_size_y));
        w_nz = (r_size_z == 7'd0) ? EW'(1) :
               ((EW'(r_size_z) > EW'(MAX_SIZE_Z)) ? EW'(MAX_SIZE_Z) : EW'(r_size_z));
        w_k7 = (r_peak_count == 4'd0) ? 7'd1 :
               ((7'(r_peak_count) > 7'(MAX_PEAKS)) ? 7'(MAX_PEAKS) : 7'(r_peak_count));
        w_k   = KW'(w_k7);
        w_km1 = w_k - KW'(1);
    end

    assign w_accept   = i_smp.valid && i_smp.ready;
    assign w_judge    = (r_x >= XW'(2)) && (r_y >= YW'(2)) && (r_z >= ZW'(2));
    assign w_end_z    = (EW'(r_z) + EW'(1)) >= w_nz;
    assign w_end_y    = (EW'(r_y) + EW'(1)) >= w_ny;
    assign w_end_x    = (EW'(r_x) + EW'(1)) >= w_nx;
    assign w_nbr_last = (r_ax == 2'd2) && (r_ay == 2'd2) && (r_az == 2'd2);
    assign w_out_xfer = o_pk.valid && o_pk.ready;
    assign w_out_last = r_rank == w_km1;
    assign w_insert   = r_ok && w_gt[w_km1[PIW-1:0]];
    assign w_rd_s     = w_rdata;
    assign w_cand_crd = {XW'(r_x - XW'(1)), YW'(r_y - YW'(1)), ZW'(r_z - ZW'(1))};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            vlp_pkg::S_IDLE:   if (w_accept) begin
                n_state = w_judge ? vlp_pkg::S_CENTER : vlp_pkg::S_ADV;
            end
            vlp_pkg::S_CENTER: n_state = vlp_pkg::S_NBR;
            vlp_pkg::S_NBR:    if (w_nbr_last) begin
                n_state = vlp_pkg::S_DRAIN;
            end
            vlp_pkg::S_DRAIN:  n_state = vlp_pkg::S_INSERT;
            vlp_pkg::S_INSERT: n_state = vlp_pkg::S_ADV;
            vlp_pkg::S_ADV:    n_state = (w_end_z && w_end_y && w_end_x) ?
                                         vlp_pkg::S_EMIT : vlp_pkg::S_IDLE;
            vlp_pkg::S_EMIT:   if (w_out_xfer && w_out_last) begin
                n_state = vlp_pkg::S_IDLE;
            end
            default:           n_state = vlp_pkg::S_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        i_smp.ready = 1'b0;
        o_pk.valid  = 1'b0;
        w_ctl       = '0;
        w_raddr     = f_addr(f_mod3(3'(r_plane) + 3'd1 + 3'(r_ax)),
                             YW'(r_y - YW'(2) + YW'(r_ay)), ZW'(r_z - ZW'(2) + ZW'(r_az)));
        case (r_state)
            vlp_pkg::S_IDLE:   begin
                i_smp.ready = 1'b1;
                w_ctl.seed  = w_accept && !r_first_seen;
            end
            vlp_pkg::S_CENTER: begin
                w_raddr = f_addr(f_mod3(3'(r_plane) + 3'd2), YW'(r_y - YW'(1)),
                                 ZW'(r_z - ZW'(1)));
            end
            vlp_pkg::S_INSERT: w_ctl.ins = w_insert;
            vlp_pkg::S_EMIT:   begin
                o_pk.valid = 1'b1;
                w_ctl.pop  = w_out_xfer;
            end
            default:           ;
        endcase
    end

    assign w_waddr = f_addr(r_plane, r_y, r_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= vlp_pkg::S_IDLE;
            r_size_x     <= 7'd64;
            r_size_y     <= 7'd64;
            r_size_z     <= 7'd64;
            r_peak_count <= 4'd8;
            r_x          <= '0;
            r_y          <= '0;
            r_z          <= '0;
            r_plane      <= '0;
            r_first_seen <= 1'b0;
            r_ax         <= '0;
            r_ay         <= '0;
            r_az         <= '0;
            r_rd_ctr     <= 1'b0;
            r_rd_nbr     <= 1'b0;
            r_ok         <= 1'b0;
            r_rank       <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ctr <= r_state == vlp_pkg::S_CENTER;
            r_rd_nbr <= (r_state == vlp_pkg::S_NBR) &&
                        !((r_ax == 2'd1) && (r_ay == 2'd1) && (r_az == 2'd1));

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vlp_pkg::CFG_SIZE_X:     r_size_x     <= i_cfg_data;
                    vlp_pkg::CFG_SIZE_Y:     r_size_y     <= i_cfg_data;
                    vlp_pkg::CFG_SIZE_Z:     r_size_z     <= i_cfg_data;
                    vlp_pkg::CFG_PEAK_COUNT: r_peak_count <= i_cfg_data[3:0];
                    default:                 ;
                endcase
                r_x          <= '0;
                r_y          <= '0;
                r_z          <= '0;
                r_plane      <= '0;
                r_first_seen <= 1'b0;
            end

            if (w_accept) begin
                r_first_seen <= 1'b1;
            end

            if (r_state == vlp_pkg::S_CENTER) begin
                r_ok <= 1'b1;
                r_ax <= '0;
                r_ay <= '0;
                r_az <= '0;
            end

            if (r_state == vlp_pkg::S_NBR) begin
                if (r_az == 2'd2) begin
                    r_az <= '0;
                    if (r_ay == 2'd2) begin
                        r_ay <= '0;
                        r_ax <= r_ax + 2'd1;
                    end else begin
                        r_ay <= r_ay + 2'd1;
                    end
                end else begin
                    r_az <= r_az + 2'd1;
                end
            end

            // The center comes back first, so every neighbor compares against it.
            if (r_rd_nbr && !(r_cand > w_rd_s)) begin
                r_ok <= 1'b0;
            end

            if (r_state == vlp_pkg::S_ADV) begin
                if (!w_end_z) begin
                    r_z <= r_z + ZW'(1);
                end else begin
                    r_z <= '0;
                    if (!w_end_y) begin
                        r_y <= r_y + YW'(1);
                    end else begin
                        r_y <= '0;
                        if (!w_end_x) begin
                            r_x     <= r_x + XW'(1);
                            r_plane <= (r_plane == 2'd2) ? 2'd0 : r_plane + 2'd1;
                        end
                    end
                end
            end

            if (w_out_xfer) begin
                if (w_out_last) begin
                    r_rank       <= '0;
                    r_x          <= '0;
                    r_y          <= '0;
                    r_z          <= '0;
                    r_plane      <= '0;
                    r_first_seen <= 1'b0;
                end else begin
                    r_rank <= r_rank + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_ctr) begin
            r_cand <= w_rd_s;
        end
    end

    vlp_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_planes (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_waddr),
        .i_wdata (i_smp.sample),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic signed [SAMPLE_WIDTH-1:0] w_cell_cand;
    assign w_cell_cand = w_ctl.seed ? i_smp.sample : r_cand;

    for (genvar g = 0; g < MAX_PEAKS; g++) begin : g_cell
        logic                           w_pge;
        logic signed [SAMPLE_WIDTH-1:0] w_pval, w_nval;
        logic [CRW-1:0]                 w_pcrd, w_ncrd;

        if (g == 0) begin : g_head
            assign w_pge  = 1'b0;
            assign w_pval = '0;
            assign w_pcrd = '0;
        end else begin : g_body
            assign w_pge  = w_ge[g-1];
            assign w_pval = w_val[g-1];
            assign w_pcrd = w_crd[g-1];
        end
        if (g == MAX_PEAKS - 1) begin : g_tail
            assign w_nval = '0;
            assign w_ncrd = '0;
        end else begin : g_inner
            assign w_nval = w_val[g+1];
            assign w_ncrd = w_crd[g+1];
        end

        vlp_cell #(
            .VW  (SAMPLE_WIDTH),
            .CRW (CRW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_en       (KW'(g) < w_k),
            .i_cand_val (w_cell_cand),
            .i_cand_crd (w_cand_crd),
            .i_prev_ge  (w_pge),
            .i_prev_val (w_pval),
            .i_prev_crd (w_pcrd),
            .i_next_val (w_nval),
            .i_next_crd (w_ncrd),
            .o_ge       (w_ge[g]),
            .o_gt       (w_gt[g]),
            .o_val      (w_val[g]),
            .o_crd      (w_crd[g])
        );
    end

    // Output fields are the low bits of the head cell and of the rank counter, zero-extended.
    logic [KW+2:0]            w_rank_ext;
    logic [SAMPLE_WIDTH+31:0] w_val_ext;
    logic [XW+5:0]            w_x_ext;
    logic [YW+5:0]            w_y_ext;
    logic [ZW+5:0]            w_z_ext;

    assign w_rank_ext      = {3'b0, r_rank};
    assign w_val_ext       = {32'b0, w_val[0]};
    assign w_x_ext         = {6'b0, w_crd[0][CRW-1 -: XW]};
    assign w_y_ext         = {6'b0, w_crd[0][ZW +: YW]};
    assign w_z_ext         = {6'b0, w_crd[0][ZW-1:0]};
    assign o_pk.rank       = w_rank_ext[2:0];
    assign o_pk.peak_value = w_val_ext[31:0];
    assign o_pk.peak_x     = w_x_ext[5:0];
    assign o_pk.peak_y     = w_y_ext[5:0];
    assign o_pk.peak_z     = w_z_ext[5:0];
    assign o_pk.last_peak  = w_out_last;
endmodule

`default_nettype wire

@@ sim/tb_volume_local_peak_top_list.sv @@
// ----------------------------------------------------------------------------
// tb_volume_local_peak_top_list
// Self-checking bench for the volume local peak finder. A queue of voxel
// volumes feeds a random-gap driver, an internal model predicts each list
// readout, and a random-stall monitor compares every peak transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_volume_local_peak_top_list;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  rank;
        logic [31:0] value;
        logic [5:0]  px;
        logic [5:0]  py;
        logic [5:0]  pz;
        logic        last;
    } t_peak;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [vlp_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx = '0;
    logic [vlp_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;

    vlp_in_if #(.SAMPLE_WIDTH(32)) smp_if ();
    vlp_out_if pk_if ();

    volume_local_peak_top_list i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp     (smp_if.sink),
        .o_pk      (pk_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Model state. Keys are biased samples so unsigned compare orders them.
    logic [31:0] plane_mem [3][4096];
    logic [31:0] top_val [8];
    logic [5:0]  top_x [8], top_y [8], top_z [8];
    int          scan_x, scan_y, scan_z;
    bit          seeded;
    int          sz_x = 64, sz_y = 64, sz_z = 64, keep_n = 8;

    logic [31:0] voxel_queue [$];
    t_peak       peak_queue [$];
    int          fail_cnt = 0;
    int          sent_cnt = 0;
    int          got_cnt = 0;
    bit          quiet_sender = 1'b0;
    bit          quiet_receiver = 1'b0;
    bit          tx_hold = 1'b0;

    function automatic int clip(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [31:0] voxel_at(int x, int y, int z);
        int idx;
        idx = y * clip(sz_z, 64) + z;
        if (idx >= 4096 || idx < 0) return 32'd0;
        return plane_mem[x % 3][idx];
    endfunction

    task automatic restart_scan();
        scan_x = 0;
        scan_y = 0;
        scan_z = 0;
        seeded = 1'b0;
    endtask

    task automatic rank_voxel(int cx, int cy, int cz);
        logic [31:0] c;
        int k, pos;
        c = voxel_at(cx, cy, cz);
        k = clip(keep_n, 8);
        for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dz = -1; dz <= 1; dz++)
                    if (!(dx == 0 && dy == 0 && dz == 0))
                        if (!(c > voxel_at(cx + dx, cy + dy, cz + dz))) return;
        if (!(c > top_val[k-1])) return;
        pos = 0;
        while (pos < k - 1 && c < top_val[pos]) pos++;
        for (int i = k - 1; i > pos; i--) begin
            top_val[i] = top_val[i-1];
            top_x[i] = top_x[i-1];
            top_y[i] = top_y[i-1];
            top_z[i] = top_z[i-1];
        end
        top_val[pos] = c;
        top_x[pos] = 6'(cx);
        top_y[pos] = 6'(cy);
        top_z[pos] = 6'(cz);
    endtask

    task automatic predict_peaks(logic [31:0] smp);
        logic [31:0] key;
        int nx, ny, nz, k;
        t_peak p;
        nx = clip(sz_x, 64);
        ny = clip(sz_y, 64);
        nz = clip(sz_z, 64);
        key = smp ^ 32'h8000_0000;
        if (!seeded) begin
            for (int i = 0; i < 8; i++) begin
                top_val[i] = key;
                top_x[i] = '0;
                top_y[i] = '0;
                top_z[i] = '0;
            end
            seeded = 1'b1;
        end
        if (scan_y * nz + scan_z < 4096) plane_mem[scan_x % 3][scan_y * nz + scan_z] = key;
        if (scan_x >= 2 && scan_y >= 2 && scan_z >= 2)
            rank_voxel(scan_x - 1, scan_y - 1, scan_z - 1);
        if (scan_z + 1 < nz) begin
            scan_z++;
            return;
        end
        scan_z = 0;
        if (scan_y + 1 < ny) begin
            scan_y++;
            return;
        end
        scan_y = 0;
        if (scan_x + 1 < nx) begin
            scan_x++;
            return;
        end
        k = clip(keep_n, 8);
        for (int i = 0; i < k; i++) begin
            p.rank = i[2:0];
            p.value = top_val[i] ^ 32'h8000_0000;
            p.px = top_x[i];
            p.py = top_y[i];
            p.pz = top_z[i];
            p.last = (i + 1 == k);
            peak_queue.push_back(p);
        end
        restart_scan();
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout at %0t", $realtime);
        $display("FAILURE");
        $finish;
    end

    // Driver: the model runs on the accepted transfer.
    initial begin
        smp_if.valid = 1'b0;
        smp_if.sample = '0;
    end

    always @(posedge i_clk) begin
        if (smp_if.valid && smp_if.ready) begin
            predict_peaks(smp_if.sample);
            sent_cnt++;
        end
        if (!smp_if.valid || smp_if.ready) begin
            if (i_rst_n && !tx_hold && voxel_queue.size() > 0 &&
                (quiet_sender || $urandom_range(99) >= 36)) begin
                smp_if.valid <= 1'b1;
                smp_if.sample <= voxel_queue.pop_front();
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // Monitor
    initial pk_if.ready = 1'b0;

    always @(posedge i_clk) begin
        t_peak want;
        if (pk_if.valid && pk_if.ready) begin
            got_cnt++;
            if (peak_queue.size() == 0) begin
                $display("%0t: unexpected peak, expected none, actual rank %0d value %h",
                         $realtime, pk_if.rank, pk_if.peak_value);
                fail_cnt++;
            end else begin
                want = peak_queue.pop_front();
                if (pk_if.rank !== want.rank || pk_if.peak_value !== want.value ||
                    pk_if.peak_x !== want.px || pk_if.peak_y !== want.py ||
                    pk_if.peak_z !== want.pz || pk_if.last_peak !== want.last) begin
                    $display("%0t: peak mismatch expected %0d %h (%0d,%0d,%0d) %b",
                             $realtime, want.rank, want.value, want.px, want.py,
                             want.pz, want.last);
                    $display("%0t:                 actual %0d %h (%0d,%0d,%0d) %b",
                             $realtime, pk_if.rank, pk_if.peak_value, pk_if.peak_x,
                             pk_if.peak_y, pk_if.peak_z, pk_if.last_peak);
                    fail_cnt++;
                end
            end
        end
        pk_if.ready <= quiet_receiver || ($urandom_range(99) >= 36);
    end

    task automatic settle();
        while (voxel_queue.size() > 0 || smp_if.valid) @(posedge i_clk);
        while (peak_queue.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [vlp_pkg::CFG_IDX_WIDTH-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[vlp_pkg::CFG_DATA_WIDTH-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            vlp_pkg::CFG_SIZE_X:     sz_x = val & 7'h7f;
            vlp_pkg::CFG_SIZE_Y:     sz_y = val & 7'h7f;
            vlp_pkg::CFG_SIZE_Z:     sz_z = val & 7'h7f;
            vlp_pkg::CFG_PEAK_COUNT: keep_n = val & 4'hf;
            default: ;
        endcase
        restart_scan();
    endtask

    task automatic set_volume(int x, int y, int z, int k);
        write_reg(vlp_pkg::CFG_SIZE_X, x);
        write_reg(vlp_pkg::CFG_SIZE_Y, y);
        write_reg(vlp_pkg::CFG_SIZE_Z, z);
        write_reg(vlp_pkg::CFG_PEAK_COUNT, k);
    endtask

    // Random samples, mostly from narrow ranges, make ties and local peaks likely.
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'h7fff_fffc + $urandom_range(3);
            default: return $urandom_range(7) - 3;
        endcase
    endfunction

    initial begin
        int n;
        int nx, ny, nz;
        restart_scan();
        for (int p = 0; p < 3; p++)
            for (int i = 0; i < 4096; i++) plane_mem[p][i] = '0;
        for (int i = 0; i < 8; i++) begin
            top_val[i] = '0;
            top_x[i] = '0;
            top_y[i] = '0;
            top_z[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a 3x3x3 volume with one central peak, the minimum and -1 around it.
        set_volume(3, 3, 3, 8);
        for (int i = 0; i < 27; i++)
            voxel_queue.push_back(i == 13 ? 32'h7fff_ffff :
                                  (i[0] ? 32'h8000_0000 : 32'hffff_ffff));
        settle();
        // Tiny volume: no interior, only the seed; out of range counts clamped.
        set_volume(0, 1, 127, 0);
        n = 64;
        repeat (n) voxel_queue.push_back(pick_sample());
        settle();
        set_volume(3, 3, 3, 15);
        repeat (27) voxel_queue.push_back(32'h0001_0000);
        settle();
        // Extent 64 along y with a minimal x and z.
        set_volume(1, 64, 1, 1);
        repeat (64) voxel_queue.push_back(pick_sample());
        settle();
        // Writing an unchanged value mid-volume restarts the scan.
        set_volume(4, 4, 4, 3);
        repeat (10) voxel_queue.push_back(pick_sample());
        settle();
        write_reg(vlp_pkg::CFG_PEAK_COUNT, 3);

        // Random 3x3x3 volumes; the second and third have no sender gaps, the last two no receiver stalls.
        for (int v = 0; v < 4; v++) begin
            nx = 3;
            ny = 3;
            nz = 3;
            set_volume(nx, ny, nz, $urandom_range(1, 8));
            quiet_sender = (v == 1 || v == 2);
            quiet_receiver = (v == 2 || v == 3);
            tx_hold = (v == 3);
            for (int i = 0; i < nx * ny * nz; i++) voxel_queue.push_back(pick_sample());
            if (tx_hold) begin
                while (peak_queue.size() > 0) @(posedge i_clk);
                tx_hold = 1'b0;
            end
            settle();
        end
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;

        $display("Sent %0d voxels over directed and random volumes, checked %0d peaks.",
                 sent_cnt, got_cnt);
        if (fail_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
